// ===== hw/rtl/ecg_fifo_word_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// ECG FIFO word classifier assertion macros
// Shared assertion shorthands for the classifier checker.
// ----------------------------------------------------------------------------
`ifndef ECG_FIFO_WORD_CLASSIFIER_MACROS_SVH
`define ECG_FIFO_WORD_CLASSIFIER_MACROS_SVH

// Assertion that is switched off while reset is held.
`define ECG_FWC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked in every cycle, reset included.
`define ECG_FWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ecg_fwc_pkg.sv =====
// ----------------------------------------------------------------------------
// ECG FIFO word classifier package
// Types, codes and status bit positions shared by the classifier modules.
// ----------------------------------------------------------------------------
package ecg_fwc_pkg;

    localparam int NUM_COUNTERS = 10;
    localparam int SEL_W        = 4;
    localparam int Q_DEPTH      = 2;   // must be a power of two

    // Event counter indexes.
    localparam int CNT_PLL_SEEN = 0;
    localparam int CNT_PLL_EDGE = 1;
    localparam int CNT_EOVF     = 2;
    localparam int CNT_SAMPLE   = 3;
    localparam int CNT_VALID    = 4;
    localparam int CNT_LAST     = 5;
    localparam int CNT_FAST     = 6;
    localparam int CNT_EMPTY    = 7;
    localparam int CNT_TAG_OVF  = 8;
    localparam int CNT_UNKNOWN  = 9;

    // Status word bit positions.
    localparam int ST_EINT    = 23;
    localparam int ST_EOVF    = 22;
    localparam int ST_DCLOFF  = 20;
    localparam int ST_PLL     = 7;
    localparam int ST_LDOFF_PH = 3;
    localparam int ST_LDOFF_PL = 2;
    localparam int ST_LDOFF_NH = 1;
    localparam int ST_LDOFF_NL = 0;

    // FIFO word tags.
    localparam logic [2:0] TAG_VALID      = 3'd0;
    localparam logic [2:0] TAG_FAST       = 3'd1;
    localparam logic [2:0] TAG_VALID_LAST = 3'd2;
    localparam logic [2:0] TAG_FAST_LAST  = 3'd3;
    localparam logic [2:0] TAG_EMPTY      = 3'd6;
    localparam logic [2:0] TAG_OVF        = 3'd7;

    typedef enum logic [1:0] {
        CMD_STATUS = 2'd0,
        CMD_FIFO   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_VALID   = 3'd0,
        KIND_FAST    = 3'd1,
        KIND_EMPTY   = 3'd2,
        KIND_OVF     = 3'd3,
        KIND_UNKNOWN = 3'd4,
        KIND_INFO    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        LEAD_UNKNOWN = 2'd0,
        LEAD_ON      = 2'd1,
        LEAD_OFF     = 2'd2
    } t_lead;

    // Decoded word handed from the front to the back.
    typedef struct packed {
        t_cmd                    cmd;
        t_kind                   kind;
        logic                    sample_valid;
        logic signed [15:0]      sample;
        logic                    end_burst;
        logic                    fifo_reset_request;
        logic                    eint;
        logic [NUM_COUNTERS-1:0] bump;
        logic                    pll;
        logic                    lead_off;
        logic [2:0]              lead_flags;  // {dc, negative, positive}
        logic [SEL_W-1:0]        sel;
    } t_op;

    typedef struct packed {
        t_kind              kind;
        logic               sample_valid;
        logic signed [15:0] sample;
        logic               end_burst;
        logic               fifo_reset_request;
        logic               eint;
        t_lead              lead_state;
        logic               positive_off;
        logic               negative_off;
        logic               dc_leadoff;
        logic [31:0]        counter_value;
    } t_result;

endpackage

// ===== hw/rtl/ecg_fifo_word_classifier.sv =====
// ----------------------------------------------------------------------------
// ECG FIFO word classifier: decodes front-end status and FIFO words.
// Path: front queue, back-end update, result queue, then the result ports.
// Throughput: one word per cycle unless the full result queue stalls the back end.
// Reset: synchronous; queues empty, counters zero, lead state unknown.
// ----------------------------------------------------------------------------
module ecg_fifo_word_classifier
    import ecg_fwc_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_cmd,
    input  logic [23:0]        i_word,
    input  logic [3:0]         i_counter_select,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_kind,
    output logic               o_sample_valid,
    output logic signed [15:0] o_sample,
    output logic               o_end_burst,
    output logic               o_fifo_reset_request,
    output logic               o_eint_seen,
    output logic [1:0]         o_lead_state,
    output logic               o_positive_off,
    output logic               o_negative_off,
    output logic               o_dc_leadoff,
    output logic [31:0]        o_counter_value
);

    t_op     op;
    logic    op_valid;
    logic    op_pop;
    t_result res;

    ecg_fwc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_cmd            (i_cmd),
        .i_word           (i_word),
        .i_counter_select (i_counter_select),
        .o_full           (full),
        .o_op             (op),
        .o_op_valid       (op_valid),
        .i_op_pop         (op_pop)
    );

    ecg_fwc_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_op_valid  (op_valid),
        .o_op_pop    (op_pop),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_kind               = res.kind;
    assign o_sample_valid       = res.sample_valid;
    assign o_sample             = res.sample;
    assign o_end_burst          = res.end_burst;
    assign o_fifo_reset_request = res.fifo_reset_request;
    assign o_eint_seen          = res.eint;
    assign o_lead_state         = res.lead_state;
    assign o_positive_off       = res.positive_off;
    assign o_negative_off       = res.negative_off;
    assign o_dc_leadoff         = res.dc_leadoff;
    assign o_counter_value      = res.counter_value;

endmodule

// ===== hw/rtl/ecg_fwc_fifo.sv =====
// ----------------------------------------------------------------------------
// ECG FIFO word classifier queue
// Small first-in first-out queue of fixed depth with full and empty flags.
// ----------------------------------------------------------------------------
module ecg_fwc_fifo
    import ecg_fwc_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/ecg_fwc_front.sv =====
// ----------------------------------------------------------------------------
// ECG FIFO word classifier front end
// Accepts words, decodes status bits and FIFO tags, and queues the decode.
// ----------------------------------------------------------------------------
module ecg_fwc_front
    import ecg_fwc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [1:0]       i_cmd,
    input  logic [23:0]      i_word,
    input  logic [SEL_W-1:0] i_counter_select,
    output logic             o_full,
    output t_op              o_op,
    output logic             o_op_valid,
    input  logic             i_op_pop
);

    t_op                decoded;
    logic [2:0]         tag;
    logic [$bits(t_op)-1:0] queue_out;
    logic               queue_empty;

    assign tag = i_word[5:3];

    always_comb begin
        decoded      = '0;
        decoded.cmd  = t_cmd'(i_cmd);
        decoded.kind = KIND_INFO;
        decoded.sel  = i_counter_select;
        unique case (t_cmd'(i_cmd))
            CMD_STATUS: begin
                decoded.eint = i_word[ST_EINT];
                if (i_word[ST_EOVF]) begin
                    decoded.bump[CNT_EOVF]     = 1'b1;
                    decoded.end_burst          = 1'b1;
                    decoded.fifo_reset_request = 1'b1;
                end
                decoded.pll        = i_word[ST_PLL];
                decoded.lead_flags = {i_word[ST_DCLOFF],
                                      i_word[ST_LDOFF_NH] | i_word[ST_LDOFF_NL],
                                      i_word[ST_LDOFF_PH] | i_word[ST_LDOFF_PL]};
                decoded.lead_off   = i_word[ST_DCLOFF] | (|i_word[ST_LDOFF_PH:ST_LDOFF_NL]);
            end
            CMD_FIFO: begin
                decoded.end_burst = 1'b1;
                unique case (tag)
                    TAG_VALID, TAG_VALID_LAST: begin
                        decoded.kind              = KIND_VALID;
                        decoded.sample_valid      = 1'b1;
                        decoded.sample            = signed'(i_word[23:8]);
                        decoded.bump[CNT_SAMPLE]  = 1'b1;
                        decoded.bump[CNT_VALID]   = 1'b1;
                        decoded.bump[CNT_LAST]    = (tag == TAG_VALID_LAST);
                        decoded.end_burst         = (tag == TAG_VALID_LAST);
                    end
                    TAG_FAST, TAG_FAST_LAST: begin
                        decoded.kind             = KIND_FAST;
                        decoded.bump[CNT_SAMPLE] = 1'b1;
                        decoded.bump[CNT_FAST]   = 1'b1;
                        decoded.bump[CNT_LAST]   = (tag == TAG_FAST_LAST);
                        decoded.end_burst        = (tag == TAG_FAST_LAST);
                    end
                    TAG_EMPTY: begin
                        decoded.kind            = KIND_EMPTY;
                        decoded.bump[CNT_EMPTY] = 1'b1;
                    end
                    TAG_OVF: begin
                        decoded.kind               = KIND_OVF;
                        decoded.bump[CNT_TAG_OVF]  = 1'b1;
                        decoded.bump[CNT_EOVF]     = 1'b1;
                        decoded.fifo_reset_request = 1'b1;
                    end
                    default: begin
                        decoded.kind              = KIND_UNKNOWN;
                        decoded.bump[CNT_UNKNOWN] = 1'b1;
                    end
                endcase
            end
            CMD_READ, CMD_NONE: begin
                decoded.kind = KIND_INFO;
            end
        endcase
    end

    ecg_fwc_fifo #(
        .WIDTH ($bits(t_op))
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (decoded),
        .o_full  (o_full),
        .i_pop   (i_op_pop),
        .o_data  (queue_out),
        .o_empty (queue_empty)
    );

    assign o_op       = t_op'(queue_out);
    assign o_op_valid = !queue_empty;

endmodule

// ===== hw/rtl/ecg_fwc_back.sv =====
// ----------------------------------------------------------------------------
// ECG FIFO word classifier back end
// Applies decoded words to the counters and lead state and queues results.
// ----------------------------------------------------------------------------
module ecg_fwc_back
    import ecg_fwc_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_op     i_op,
    input  logic    i_op_valid,
    output logic    o_op_pop,
    output t_result o_res,
    output logic    o_res_empty,
    input  logic    i_res_pop
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    logic [COUNTER_WIDTH-1:0] r_cnt [NUM_COUNTERS];
    logic                     r_pll_level;
    t_lead                    r_lead_state;
    logic [2:0]               r_lead_flags;

    logic [NUM_COUNTERS-1:0]  n_bump;
    logic                     n_pll_level;
    t_lead                    n_lead_state;
    logic [2:0]               n_lead_flags;
    t_result                  result;
    logic                     res_full;
    logic [$bits(t_result)-1:0] res_out;

    assign o_op_pop = i_op_valid && !res_full;

    // The PLL edge counter needs the stored level, so both PLL counters are settled here.
    always_comb begin
        n_bump       = i_op.bump;
        n_pll_level  = r_pll_level;
        n_lead_state = r_lead_state;
        n_lead_flags = r_lead_flags;
        if (i_op.cmd == CMD_STATUS) begin
            n_bump[CNT_PLL_SEEN] = i_op.pll;
            n_bump[CNT_PLL_EDGE] = i_op.pll && !r_pll_level;
            n_pll_level          = i_op.pll;
            n_lead_state         = i_op.lead_off ? LEAD_OFF : LEAD_ON;
            n_lead_flags         = i_op.lead_flags;
        end
    end

    always_comb begin
        result                    = '0;
        result.kind               = i_op.kind;
        result.sample_valid       = i_op.sample_valid;
        result.sample             = i_op.sample;
        result.end_burst          = i_op.end_burst;
        result.fifo_reset_request = i_op.fifo_reset_request;
        result.eint               = i_op.eint;
        result.lead_state         = n_lead_state;
        result.positive_off       = n_lead_flags[0];
        result.negative_off       = n_lead_flags[1];
        result.dc_leadoff         = n_lead_flags[2];
        if (i_op.cmd == CMD_READ && i_op.sel < SEL_W'(NUM_COUNTERS)) begin
            result.counter_value = 32'(r_cnt[i_op.sel]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_cnt[i] <= '0;
            end
            r_pll_level  <= 1'b0;
            r_lead_state <= LEAD_UNKNOWN;
            r_lead_flags <= '0;
        end else if (o_op_pop) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                if (n_bump[i]) begin
                    r_cnt[i] <= r_cnt[i] + CNT_ONE;
                end
            end
            r_pll_level  <= n_pll_level;
            r_lead_state <= n_lead_state;
            r_lead_flags <= n_lead_flags;
        end
    end

    ecg_fwc_fifo #(
        .WIDTH ($bits(t_result))
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_op_pop),
        .i_data  (result),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (res_out),
        .o_empty (o_res_empty)
    );

    assign o_res = t_result'(res_out);

endmodule

// ===== hw/rtl/ecg_fwc_checker.sv =====
// ----------------------------------------------------------------------------
// ECG FIFO word classifier checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "ecg_fifo_word_classifier_macros.svh"

module ecg_fwc_checker
    import ecg_fwc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic [2:0]         o_kind,
    input logic               o_sample_valid,
    input logic signed [15:0] o_sample,
    input logic               o_end_burst,
    input logic               o_fifo_reset_request,
    input logic [31:0]        o_counter_value
);

    // Both queues come out of reset drained.
    `ECG_FWC_ASSERT_ALWAYS(a_reset_drains, i_clk,
        !i_rst_n |=> empty && !full,
        "queues not empty after reset")

    `ECG_FWC_ASSERT(a_valid_kind, i_clk, i_rst_n,
        !empty && o_sample_valid |-> o_kind == KIND_VALID,
        "valid sample with wrong kind")

    `ECG_FWC_ASSERT(a_sample_zero, i_clk, i_rst_n,
        !empty && !o_sample_valid |-> o_sample == '0,
        "sample not zero without valid")

    `ECG_FWC_ASSERT(a_reset_req_ends, i_clk, i_rst_n,
        !empty && o_fifo_reset_request |-> o_end_burst,
        "FIFO reset request without end of burst")

    `ECG_FWC_ASSERT(a_count_on_read, i_clk, i_rst_n,
        !empty && o_counter_value != '0 |-> o_kind == KIND_INFO && !o_end_burst,
        "counter value on a non-read word")

endmodule

bind ecg_fifo_word_classifier ecg_fwc_checker u_ecg_fwc_checker (.*);
